/* design/olids_pkg.sv */
// Package for the ordered list block: sizes, request and status codes,
// transfer structs and the control struct broadcast to the storage cells.
// Has no dependencies; every other design file refers to it by scoped names.
package olids_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int POS_W       = 7;
    localparam int IDX_W       = $clog2(CAPACITY);

    localparam logic [1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [1:0] REQ_INS_POS   = 2'd1;
    localparam logic [1:0] REQ_DEL_POS   = 2'd2;
    localparam logic [1:0] REQ_SEARCH    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_POS   = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic [POS_W-1:0]              position;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic                   ins;
        logic                   del;
        logic [POS_W-1:0]       idx;
        logic [POS_W-1:0]       count;
        logic [VALUE_WIDTH-1:0] value;
    } t_cell_ctrl;

endpackage

/* design/olids_cell.sv */
// One storage cell of the list: holds one entry, takes its neighbor's entry
// on a shift and registers whether it matches the searched value.
// Depends on olids_pkg.
module olids_cell (
    input  logic                             i_clk,
    input  olids_pkg::t_cell_ctrl            i_ctrl,
    input  logic [olids_pkg::IDX_W-1:0]      i_index,
    input  logic [olids_pkg::VALUE_WIDTH-1:0] i_prev,
    input  logic [olids_pkg::VALUE_WIDTH-1:0] i_next,
    output logic [olids_pkg::VALUE_WIDTH-1:0] o_entry,
    output logic                             o_match
);

    logic [olids_pkg::VALUE_WIDTH-1:0] r_entry;
    logic [olids_pkg::VALUE_WIDTH-1:0] n_entry;
    logic                              r_match;
    logic [olids_pkg::POS_W-1:0]       w_pos;
    logic                              w_live;

    assign w_pos  = olids_pkg::POS_W'(i_index);
    assign w_live = (w_pos < i_ctrl.count);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (w_pos == i_ctrl.idx) begin
                n_entry = i_ctrl.value;
            end else if ((w_pos > i_ctrl.idx) && (w_pos <= i_ctrl.count)) begin
                n_entry = i_prev;
            end
        end else if (i_ctrl.del) begin
            if ((w_pos >= i_ctrl.idx) && ((w_pos + 1'b1) < i_ctrl.count)) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= w_live && (r_entry == i_ctrl.value);
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

/* design/olids_first_match.sv */
// Finds the lowest cell whose registered match flag is set and gives its
// 1-based position. Depends on olids_pkg.
module olids_first_match (
    input  logic [olids_pkg::CAPACITY-1:0] i_match,
    output logic                           o_found,
    output logic [olids_pkg::POS_W-1:0]    o_position
);

    always_comb begin
        o_found    = 1'b0;
        o_position = '0;
        for (int i = olids_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_found    = 1'b1;
                o_position = olids_pkg::POS_W'(i + 1);
            end
        end
    end

endmodule

/* design/ordered_list_insert_delete_search.sv */
// Top level of the ordered list: request decode, entry count, the row of
// storage cells and the result register.
// Depends on olids_pkg, olids_cell and olids_first_match.
//
// Usage: drive i_req and raise start; a request transfers at a rising edge
// where start is high and busy is low. Each request gives exactly one
// result on o_rsp, shown for one cycle with o_strobe high, in the cycle
// after the request transfer. The receiver cannot stall it.
// Busy is high for one cycle, while the result is shown, so the block takes
// no new request before its result is out. Every cell registers its compare
// at the request edge and the first-match encoder reads those flags in the
// result cycle. Inserts and deletes shift the cells from the request
// position on at the request edge.
// Reset (i_rst_n low at a rising edge) empties the list and drops any
// pending result; the stored entries keep stale data that is never read.
module ordered_list_insert_delete_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  olids_pkg::t_req     i_req,
    output logic                o_strobe,
    output olids_pkg::t_rsp     o_rsp
);

    localparam logic [olids_pkg::POS_W-1:0] CAP_COUNT = olids_pkg::POS_W'(olids_pkg::CAPACITY);

    logic                          r_pending;
    logic [olids_pkg::POS_W-1:0]   r_count;
    logic [olids_pkg::POS_W-1:0]   n_count;
    logic [2:0]                    r_status;
    logic [2:0]                    n_status;
    logic                          r_search;
    logic                          w_accept;
    logic                          w_pos_ok;
    logic                          w_full;
    olids_pkg::t_cell_ctrl         w_ctrl;
    logic [olids_pkg::VALUE_WIDTH-1:0] w_entry [olids_pkg::CAPACITY];
    logic [olids_pkg::CAPACITY-1:0]    w_match;
    logic                          w_found;
    logic [olids_pkg::POS_W-1:0]   w_found_pos;

    assign w_accept = start && !r_pending;
    assign w_pos_ok = (i_req.position != '0) && (i_req.position <= r_count);
    assign w_full   = (r_count >= CAP_COUNT);

    always_comb begin
        n_status     = olids_pkg::ST_OK;
        n_count      = r_count;
        w_ctrl.ins   = 1'b0;
        w_ctrl.del   = 1'b0;
        w_ctrl.idx   = i_req.position - 1'b1;
        w_ctrl.count = r_count;
        w_ctrl.value = i_req.value;
        case (i_req.req_type)
            olids_pkg::REQ_INS_FRONT: begin
                w_ctrl.idx = '0;
                if (w_full) begin
                    n_status = olids_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            olids_pkg::REQ_INS_POS: begin
                if (!w_pos_ok) begin
                    n_status = olids_pkg::ST_BAD_POS;
                end else if (w_full) begin
                    n_status = olids_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            olids_pkg::REQ_DEL_POS: begin
                if (r_count == '0) begin
                    n_status = olids_pkg::ST_EMPTY;
                end else if (!w_pos_ok) begin
                    n_status = olids_pkg::ST_BAD_POS;
                end else begin
                    w_ctrl.del = w_accept;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
                n_status = olids_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < olids_pkg::CAPACITY; g++) begin : g_cell
            logic [olids_pkg::VALUE_WIDTH-1:0] w_prev;
            logic [olids_pkg::VALUE_WIDTH-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_prev
                assign w_prev = w_entry[g-1];
            end
            if (g == olids_pkg::CAPACITY - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid_next
                assign w_next = w_entry[g+1];
            end
            olids_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_index (olids_pkg::IDX_W'(g)),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_entry (w_entry[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    olids_first_match u_first_match (
        .i_match    (w_match),
        .o_found    (w_found),
        .o_position (w_found_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_count   <= '0;
        end else begin
            r_pending <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
        if (w_accept) begin
            r_status <= n_status;
            r_search <= (i_req.req_type == olids_pkg::REQ_SEARCH);
        end
    end

    assign busy     = r_pending;
    assign o_strobe = r_pending;

    always_comb begin
        o_rsp.status         = r_status;
        o_rsp.found_position = '0;
        o_rsp.entry_count    = r_count;
        if (r_search && w_found) begin
            o_rsp.status         = olids_pkg::ST_OK;
            o_rsp.found_position = w_found_pos;
        end
    end

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && o_strobe))
        else $error("busy did not follow a request transfer");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy))
        else $error("result without a preceding request transfer");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_COUNT)
        else $error("entry count above capacity");

    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_rsp.found_position != '0)) |->
        (r_search && (o_rsp.status == olids_pkg::ST_OK)
         && (o_rsp.found_position <= r_count)))
        else $error("found position given outside a successful search");

endmodule
